// ===== rtl/amaf_pkg.sv =====
package amaf_pkg;

   localparam int EXACT_DEPTH_DEF = 64;
   localparam int RULE_DEPTH_DEF  = 16;
   localparam int QUEUE_DEPTH     = 2;
   localparam int ADDR_W          = 32;
   localparam int COUNT_W         = 7;

   typedef enum logic [1:0] {
      KIND_CHECK     = 2'd0,
      KIND_ADD_EXACT = 2'd1,
      KIND_ADD_RULE  = 2'd2,
      KIND_CLEAR     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE   = 2'd0,
      STATUS_LOCKED = 2'd1,
      STATUS_FULL   = 2'd2
   } status_type;

   // what the back end has to do with a queued beat
   typedef enum logic [3:0] {
      ACT_PASS,
      ACT_LOOKUP,
      ACT_ADD_EXACT,
      ACT_ADD_RULE,
      ACT_CLEAR,
      ACT_LOCKED_EXACT,
      ACT_LOCKED_RULE,
      ACT_LOCKED_CLEAR,
      ACT_SKIP_EXACT,
      ACT_SKIP_RULE
   } action_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN_EXACT,
      BK_SCAN_RULE,
      BK_REPLY
   } state_type;

   typedef struct packed {
      action_type          act;
      logic [ADDR_W-1:0]   key;
      logic [ADDR_W-1:0]   msk;
   } item_type;

endpackage

// ===== rtl/amaf_front.sv =====
module amaf_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [1:0]                        req_kind,
   input  logic [63:0]                       req_peer_ipport,
   input  logic [7:0]                        req_operation_class,
   input  logic [amaf_pkg::ADDR_W-1:0]       req_entry_address,
   input  logic [amaf_pkg::ADDR_W-1:0]       req_entry_mask,
   input  logic [7:0]                        enabled_operation_mask,
   output logic                              item_valid,
   input  logic                              item_pop,
   output amaf_pkg::item_type                item
);

   localparam int QW = (amaf_pkg::QUEUE_DEPTH > 1) ? $clog2(amaf_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(amaf_pkg::QUEUE_DEPTH + 1);

   amaf_pkg::item_type q_ff [amaf_pkg::QUEUE_DEPTH];
   logic [QW-1:0]      wptr_ff, wptr_in;
   logic [QW-1:0]      rptr_ff, rptr_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   amaf_pkg::item_type cls_item;
   logic               locked;
   logic               push_ok;
   logic               pop_ok;

   // classify the beat on entry
   always_comb begin
      locked       = enabled_operation_mask != 8'd0;
      cls_item.key = req_entry_address;
      cls_item.msk = req_entry_mask;
      case (amaf_pkg::kind_type'(req_kind))
         amaf_pkg::KIND_CHECK: begin
            cls_item.key = req_peer_ipport[amaf_pkg::ADDR_W-1:0];
            if (((enabled_operation_mask & req_operation_class) != 8'd0) &&
                (req_peer_ipport[amaf_pkg::ADDR_W-1:0] != '0)) begin
               cls_item.act = amaf_pkg::ACT_LOOKUP;
            end else begin
               cls_item.act = amaf_pkg::ACT_PASS;
            end
         end
         amaf_pkg::KIND_ADD_EXACT: begin
            if (locked) begin
               cls_item.act = amaf_pkg::ACT_LOCKED_EXACT;
            end else if (req_entry_address == '0) begin
               cls_item.act = amaf_pkg::ACT_SKIP_EXACT;
            end else begin
               cls_item.act = amaf_pkg::ACT_ADD_EXACT;
            end
         end
         amaf_pkg::KIND_ADD_RULE: begin
            cls_item.key = req_entry_address & req_entry_mask;
            if (locked) begin
               cls_item.act = amaf_pkg::ACT_LOCKED_RULE;
            end else if ((req_entry_address == '0) || (req_entry_mask == '0)) begin
               cls_item.act = amaf_pkg::ACT_SKIP_RULE;
            end else begin
               cls_item.act = amaf_pkg::ACT_ADD_RULE;
            end
         end
         default: begin
            cls_item.act = locked ? amaf_pkg::ACT_LOCKED_CLEAR : amaf_pkg::ACT_CLEAR;
         end
      endcase
   end

   assign req_full   = cnt_ff == CW'(amaf_pkg::QUEUE_DEPTH);
   assign item_valid = cnt_ff != '0;
   assign item       = q_ff[rptr_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = item_pop && item_valid;

   always_comb begin
      wptr_in = push_ok ? wptr_ff + QW'(1) : wptr_ff;
      rptr_in = pop_ok ? rptr_ff + QW'(1) : rptr_ff;
      cnt_in  = cnt_ff + CW'(push_ok) - CW'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wptr_ff] <= cls_item;
      end
   end

endmodule

// ===== rtl/amaf_back.sv =====
module amaf_back #(
   parameter int EXACT_DEPTH = amaf_pkg::EXACT_DEPTH_DEF,
   parameter int RULE_DEPTH  = amaf_pkg::RULE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               item_valid,
   output logic                               item_pop,
   input  amaf_pkg::item_type                 item,
   input  logic                               rsp_pop,
   output logic                               rsp_empty,
   output logic                               rsp_denied,
   output logic [1:0]                         rsp_status,
   output logic [amaf_pkg::COUNT_W-1:0]       rsp_entry_count
);

   localparam int EW = $clog2(EXACT_DEPTH + 1);
   localparam int RW = $clog2(RULE_DEPTH + 1);
   localparam int EA = (EXACT_DEPTH > 1) ? $clog2(EXACT_DEPTH) : 1;
   localparam int RA = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
   localparam int AW = amaf_pkg::ADDR_W;

   logic [AW-1:0]   exact_mem [EXACT_DEPTH];
   logic [2*AW-1:0] rule_mem  [RULE_DEPTH];

   amaf_pkg::state_type  state_ff, state_in;
   amaf_pkg::action_type act_ff, act_in;
   logic [AW-1:0]        key_ff, key_in;
   logic [AW-1:0]        msk_ff, msk_in;
   logic                 hit_ff, hit_in;
   logic [EW-1:0]        ex_used_ff, ex_used_in;
   logic [RW-1:0]        ru_used_ff, ru_used_in;
   logic [EW-1:0]        ex_idx_ff, ex_idx_in;
   logic [RW-1:0]        ru_idx_ff, ru_idx_in;
   logic                 ex_pend_ff, ex_pend_in;
   logic                 ru_pend_ff, ru_pend_in;
   logic [AW-1:0]        ex_rdata_ff;
   logic [2*AW-1:0]      ru_rdata_ff;
   logic                 rsp_vld_ff, rsp_vld_in;
   logic                 rsp_denied_ff, rsp_denied_in;
   amaf_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [amaf_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic          ex_hit, ru_hit, ex_scan_end, ru_scan_end;
   logic          ex_full, ru_full, out_free;
   logic          ex_we, ru_we;
   logic [31:0]   ex_cnt, ru_cnt;

   always_comb begin
      ex_hit      = ex_pend_ff && (ex_rdata_ff == key_ff);
      ru_hit      = ru_pend_ff && ((key_ff & ru_rdata_ff[2*AW-1:AW]) == ru_rdata_ff[AW-1:0]);
      ex_scan_end = !ex_pend_ff && (ex_idx_ff == ex_used_ff);
      ru_scan_end = !ru_pend_ff && (ru_idx_ff == ru_used_ff);
      ex_full     = ex_used_ff == EW'(EXACT_DEPTH);
      ru_full     = ru_used_ff == RW'(RULE_DEPTH);
      out_free    = !rsp_vld_ff || rsp_pop;
      ex_cnt      = 32'(ex_used_ff);
      ru_cnt      = 32'(ru_used_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         amaf_pkg::BK_IDLE: begin
            if (item_valid) begin
               if ((item.act == amaf_pkg::ACT_LOOKUP) ||
                   (item.act == amaf_pkg::ACT_ADD_EXACT)) begin
                  state_in = amaf_pkg::BK_SCAN_EXACT;
               end else begin
                  state_in = amaf_pkg::BK_REPLY;
               end
            end
         end
         amaf_pkg::BK_SCAN_EXACT: begin
            if (ex_hit) begin
               state_in = amaf_pkg::BK_REPLY;
            end else if (ex_scan_end) begin
               state_in = (act_ff == amaf_pkg::ACT_LOOKUP) ? amaf_pkg::BK_SCAN_RULE
                                                           : amaf_pkg::BK_REPLY;
            end
         end
         amaf_pkg::BK_SCAN_RULE: begin
            if (ru_hit || ru_scan_end) begin
               state_in = amaf_pkg::BK_REPLY;
            end
         end
         amaf_pkg::BK_REPLY: begin
            if (out_free) begin
               state_in = amaf_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = amaf_pkg::BK_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      item_pop      = 1'b0;
      act_in        = act_ff;
      key_in        = key_ff;
      msk_in        = msk_ff;
      hit_in        = hit_ff;
      ex_used_in    = ex_used_ff;
      ru_used_in    = ru_used_ff;
      ex_idx_in     = ex_idx_ff;
      ru_idx_in     = ru_idx_ff;
      ex_pend_in    = 1'b0;
      ru_pend_in    = 1'b0;
      ex_we         = 1'b0;
      ru_we         = 1'b0;
      rsp_vld_in    = rsp_vld_ff && !rsp_pop;
      rsp_denied_in = rsp_denied_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      case (state_ff)
         amaf_pkg::BK_IDLE: begin
            item_pop = item_valid;
            if (item_valid) begin
               act_in    = item.act;
               key_in    = item.key;
               msk_in    = item.msk;
               hit_in    = 1'b0;
               ex_idx_in = '0;
               ru_idx_in = '0;
            end
         end
         amaf_pkg::BK_SCAN_EXACT: begin
            if (ex_hit) begin
               hit_in = 1'b1;
            end else if (ex_idx_ff != ex_used_ff) begin
               ex_pend_in = 1'b1;
               ex_idx_in  = ex_idx_ff + EW'(1);
            end
         end
         amaf_pkg::BK_SCAN_RULE: begin
            if (ru_hit) begin
               hit_in = 1'b1;
            end else if (ru_idx_ff != ru_used_ff) begin
               ru_pend_in = 1'b1;
               ru_idx_in  = ru_idx_ff + RW'(1);
            end
         end
         amaf_pkg::BK_REPLY: begin
            if (out_free) begin
               rsp_vld_in    = 1'b1;
               rsp_denied_in = 1'b0;
               rsp_status_in = amaf_pkg::STATUS_DONE;
               rsp_count_in  = '0;
               case (act_ff)
                  amaf_pkg::ACT_LOOKUP: begin
                     rsp_denied_in = hit_ff;
                  end
                  amaf_pkg::ACT_ADD_EXACT: begin
                     rsp_count_in = ex_cnt[amaf_pkg::COUNT_W-1:0];
                     if (!hit_ff) begin
                        if (ex_full) begin
                           rsp_status_in = amaf_pkg::STATUS_FULL;
                        end else begin
                           ex_we        = 1'b1;
                           ex_used_in   = ex_used_ff + EW'(1);
                           rsp_count_in = (ex_cnt[amaf_pkg::COUNT_W-1:0] +
                                           amaf_pkg::COUNT_W'(1));
                        end
                     end
                  end
                  amaf_pkg::ACT_ADD_RULE: begin
                     rsp_count_in = ru_cnt[amaf_pkg::COUNT_W-1:0];
                     if (ru_full) begin
                        rsp_status_in = amaf_pkg::STATUS_FULL;
                     end else begin
                        ru_we        = 1'b1;
                        ru_used_in   = ru_used_ff + RW'(1);
                        rsp_count_in = (ru_cnt[amaf_pkg::COUNT_W-1:0] +
                                        amaf_pkg::COUNT_W'(1));
                     end
                  end
                  amaf_pkg::ACT_CLEAR: begin
                     ex_used_in = '0;
                     ru_used_in = '0;
                  end
                  amaf_pkg::ACT_LOCKED_EXACT: begin
                     rsp_status_in = amaf_pkg::STATUS_LOCKED;
                     rsp_count_in  = ex_cnt[amaf_pkg::COUNT_W-1:0];
                  end
                  amaf_pkg::ACT_LOCKED_RULE: begin
                     rsp_status_in = amaf_pkg::STATUS_LOCKED;
                     rsp_count_in  = ru_cnt[amaf_pkg::COUNT_W-1:0];
                  end
                  amaf_pkg::ACT_LOCKED_CLEAR: begin
                     rsp_status_in = amaf_pkg::STATUS_LOCKED;
                  end
                  amaf_pkg::ACT_SKIP_EXACT: begin
                     rsp_count_in = ex_cnt[amaf_pkg::COUNT_W-1:0];
                  end
                  amaf_pkg::ACT_SKIP_RULE: begin
                     rsp_count_in = ru_cnt[amaf_pkg::COUNT_W-1:0];
                  end
                  default: begin
                     rsp_denied_in = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            item_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= amaf_pkg::BK_IDLE;
         ex_used_ff <= '0;
         ru_used_ff <= '0;
         ex_pend_ff <= 1'b0;
         ru_pend_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ex_used_ff <= ex_used_in;
         ru_used_ff <= ru_used_in;
         ex_pend_ff <= ex_pend_in;
         ru_pend_ff <= ru_pend_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      key_ff        <= key_in;
      msk_ff        <= msk_in;
      hit_ff        <= hit_in;
      ex_idx_ff     <= ex_idx_in;
      ru_idx_ff     <= ru_idx_in;
      rsp_denied_ff <= rsp_denied_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // exact address table: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (ex_we) begin
         exact_mem[ex_used_ff[EA-1:0]] <= key_ff;
      end
      ex_rdata_ff <= exact_mem[ex_idx_ff[EA-1:0]];
   end

   // rule table holds {mask, masked base}
   always_ff @(posedge clock) begin
      if (ru_we) begin
         rule_mem[ru_used_ff[RA-1:0]] <= {msk_ff, key_ff};
      end
      ru_rdata_ff <= rule_mem[ru_idx_ff[RA-1:0]];
   end

   assign rsp_empty       = !rsp_vld_ff;
   assign rsp_denied      = rsp_denied_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

// ===== rtl/address_mask_access_filter_unit.sv =====
// IPv4 access filter. Requests enter through a queue-style port (push/full) and
// results leave through one (empty/pop), one result per request, in order.
// A request either checks a peer address (low 32 bits of req_peer_ipport)
// against an exact-address set and a list of address/mask rules, adds an exact
// address, adds a rule, or clears both tables. Checks only deny when
// req_operation_class shares a bit with the enable mask written through
// csr_we/csr_wdata; while that mask is nonzero, inserts and clears are refused
// with status 1. Write the mask only while no request is in flight.
// Timing: the front end classifies each beat into a two-entry queue, so the
// port keeps taking requests while the back end works, until the queue fills.
// The back end handles one request at a time and scans the tables one entry
// per cycle through a registered memory read: a check scans the exact entries
// and then the rules, an exact insert scans the exact entries, and rule
// inserts, clears and unchecked requests go straight to the result register.
// A hit ends a scan early, and a result left waiting holds the back end
// until it is popped. No clearing pass is needed after reset; the tables
// start empty.
module address_mask_access_filter_unit #(
   parameter int EXACT_DEPTH = amaf_pkg::EXACT_DEPTH_DEF,
   parameter int RULE_DEPTH  = amaf_pkg::RULE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [1:0]                        req_kind,
   input  logic [63:0]                       req_peer_ipport,
   input  logic [7:0]                        req_operation_class,
   input  logic [amaf_pkg::ADDR_W-1:0]       req_entry_address,
   input  logic [amaf_pkg::ADDR_W-1:0]       req_entry_mask,
   // response channel
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic                              rsp_denied,
   output logic [1:0]                        rsp_status,
   output logic [amaf_pkg::COUNT_W-1:0]      rsp_entry_count,
   // enable mask register
   input  logic                              csr_we,
   input  logic [7:0]                        csr_wdata
);

   logic [7:0]         enabled_operation_mask_ff, enabled_operation_mask_in;
   logic               item_valid;
   logic               item_pop;
   amaf_pkg::item_type item;

   // hold the mask until the next write
   assign enabled_operation_mask_in = csr_we ? csr_wdata : enabled_operation_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_operation_mask_ff <= 8'd0;
      end else begin
         enabled_operation_mask_ff <= enabled_operation_mask_in;
      end
   end

   // front end: classify each accepted beat and queue it
   amaf_front u_front (
      .clock                  (clock),
      .reset                  (reset),
      .req_push               (req_push),
      .req_full               (req_full),
      .req_kind               (req_kind),
      .req_peer_ipport        (req_peer_ipport),
      .req_operation_class    (req_operation_class),
      .req_entry_address      (req_entry_address),
      .req_entry_mask         (req_entry_mask),
      .enabled_operation_mask (enabled_operation_mask_ff),
      .item_valid             (item_valid),
      .item_pop               (item_pop),
      .item                   (item)
   );

   // back end: table scans, updates and the response register
   amaf_back #(
      .EXACT_DEPTH (EXACT_DEPTH),
      .RULE_DEPTH  (RULE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (item_valid),
      .item_pop        (item_pop),
      .item            (item),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_denied      (rsp_denied),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule
